@@ src/rpst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region profile slot table package
// Shared request/result types, command and status codes.
// ----------------------------------------------------------------------------
package rpst_pkg;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic [2:0] ST_RESUMED   = 3'd0;
  localparam logic [2:0] ST_RECURSION = 3'd1;
  localparam logic [2:0] ST_ALLOCATED = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_STOPPED   = 3'd4;
  localparam logic [2:0] ST_UNMATCHED = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;
  localparam logic [2:0] ST_READ      = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] site_file;
    logic [19:0] site_line;
    logic [31:0] now_ticks;
    logic [4:0]  read_index;
  } rpst_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot_index;
    logic        slot_used;
    logic [31:0] slot_ticks;
    logic [31:0] slot_iterations;
    logic        slot_recursive;
    logic        parent_valid;
    logic [4:0]  parent_index;
    logic        current_valid;
    logic [4:0]  current_index;
  } rpst_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture request, start key search
    logic apply;    // perform update and build result
  } rpst_cmd_t;

endpackage

@@ src/rpst_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region profile slot table datapath
// Slot storage, parallel key compare, priority pick and update.
// ----------------------------------------------------------------------------
module rpst_datapath import rpst_pkg::*; #(
  parameter int SLOT_COUNT = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  rpst_cmd_t cmd,
  input  rpst_in_t  req,
  output rpst_out_t res
);

  localparam int IW = 5;

  rpst_in_t req_r;
  logic [SLOT_COUNT-1:0] used_r, run_r, rec_r, pok_r;
  logic [31:0] kf_r [SLOT_COUNT];
  logic [19:0] kl_r [SLOT_COUNT];
  logic [31:0] tick_r [SLOT_COUNT];
  logic [31:0] st_r [SLOT_COUNT];
  logic [31:0] iter_r [SLOT_COUNT];
  logic [IW-1:0] par_r [SLOT_COUNT];
  logic cur_ok_r;
  logic [IW-1:0] cur_r;

  // Search results, registered between load and apply.
  logic hit_r, free_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;
  logic hit_nxt, free_nxt;
  logic [IW-1:0] hit_idx_nxt, free_idx_nxt;

  always_comb begin
    hit_nxt = 1'b0;
    free_nxt = 1'b0;
    hit_idx_nxt = '0;
    free_idx_nxt = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (used_r[i] && kf_r[i] == req.site_file && kl_r[i] == req.site_line) begin
        hit_nxt = 1'b1;
        hit_idx_nxt = IW'(i);
      end
      if (!used_r[i]) begin
        free_nxt = 1'b1;
        free_idx_nxt = IW'(i);
      end
    end
  end

  logic [IW-1:0] h;
  logic [IW-1:0] f;
  logic rd_ok;
  assign h = hit_idx_r;
  assign f = free_idx_r;
  assign rd_ok = (32'(req_r.read_index) < SLOT_COUNT);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req;
      hit_r <= hit_nxt;
      free_r <= free_nxt;
      hit_idx_r <= hit_idx_nxt;
      free_idx_r <= free_idx_nxt;
    end
    if (cmd.apply) begin
      case (req_r.kind)
        KIND_START: begin
          if (hit_r) begin
            if (!run_r[h]) begin
              iter_r[h] <= iter_r[h] + 32'd1;
              st_r[h] <= req_r.now_ticks;
            end
          end else if (free_r) begin
            kf_r[f] <= req_r.site_file;
            kl_r[f] <= req_r.site_line;
            tick_r[f] <= '0;
            iter_r[f] <= 32'd1;
            st_r[f] <= req_r.now_ticks;
            par_r[f] <= cur_ok_r ? cur_r : '0;
          end
        end
        KIND_END: begin
          if (hit_r && run_r[h]) tick_r[h] <= tick_r[h] + (req_r.now_ticks - st_r[h]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      run_r <= '0;
      rec_r <= '0;
      pok_r <= '0;
      cur_ok_r <= 1'b0;
      cur_r <= '0;
    end else if (cmd.apply) begin
      case (req_r.kind)
        KIND_START: begin
          if (hit_r) begin
            if (run_r[h]) rec_r[h] <= 1'b1;
            run_r[h] <= 1'b1;
            cur_ok_r <= 1'b1;
            cur_r <= h;
          end else if (free_r) begin
            used_r[f] <= 1'b1;
            run_r[f] <= 1'b1;
            rec_r[f] <= 1'b0;
            pok_r[f] <= cur_ok_r;
            cur_ok_r <= 1'b1;
            cur_r <= f;
          end
        end
        KIND_END: begin
          if (hit_r) begin
            run_r[h] <= 1'b0;
            cur_ok_r <= pok_r[h];
            cur_r <= pok_r[h] ? par_r[h] : '0;
          end
        end
        KIND_CLEAR: begin
          used_r <= '0;
          run_r <= '0;
          pok_r <= '0;
          cur_ok_r <= 1'b0;
          cur_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // Remembers whether the start found its slot already running.
  logic res_rec_seen_r;
  always_ff @(posedge clk) begin
    if (cmd.apply) res_rec_seen_r <= hit_r && run_r[h];
  end

  // Result is built after the update, from the updated slot state.
  logic          rep;
  logic [IW-1:0] ri;
  logic [2:0]    rs;
  logic [4:0]    rsi;

  always_comb begin
    rep = 1'b0;
    ri = '0;
    rs = ST_READ;
    rsi = '0;
    case (req_r.kind)
      KIND_START: begin
        if (hit_r) begin
          rep = 1'b1; ri = h; rsi = 5'(h);
          rs = rec_r[h] && run_r[h] && res_rec_seen_r ? ST_RECURSION : ST_RESUMED;
        end else if (free_r) begin
          rep = 1'b1; ri = f; rsi = 5'(f); rs = ST_ALLOCATED;
        end else begin
          rs = ST_FULL;
        end
      end
      KIND_END: begin
        if (hit_r) begin
          rep = 1'b1; ri = h; rsi = 5'(h); rs = ST_STOPPED;
        end else begin
          rs = ST_UNMATCHED;
        end
      end
      KIND_CLEAR: rs = ST_CLEARED;
      default: begin
        rep = rd_ok; ri = req_r.read_index[IW-1:0]; rsi = req_r.read_index; rs = ST_READ;
      end
    endcase
  end

  always_comb begin
    res = '0;
    res.status = rs;
    res.slot_index = rsi;
    if (rep && used_r[ri]) begin
      res.slot_used = 1'b1;
      res.slot_ticks = tick_r[ri];
      res.slot_iterations = iter_r[ri];
      res.slot_recursive = rec_r[ri];
      res.parent_valid = pok_r[ri];
      res.parent_index = pok_r[ri] ? 5'(par_r[ri]) : '0;
    end
    res.current_valid = cur_ok_r;
    res.current_index = cur_ok_r ? 5'(cur_r) : '0;
  end

endmodule

@@ src/rpst_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region profile slot table controller
// Sequences search, update and result delivery for one request.
// ----------------------------------------------------------------------------
module rpst_ctrl import rpst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output rpst_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_APPLY = 2'd1;
  localparam logic [1:0] S_SHOW  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cmd.load  = (state_r == S_IDLE) && in_valid;
  assign cmd.apply = (state_r == S_APPLY);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_SHOW;
      S_SHOW:  state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/region_profile_slot_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region profile slot table
// Associative table of code-region timers keyed by file id and line.
// ----------------------------------------------------------------------------
// out_valid rises once the controller has passed through its apply and show
// states after the edge that accepts the request, and in_stall stays high until
// the result handshake, so a new request waits for the last one to finish its
// search, update, result register and handshake steps.
// Reset clears all used, running and parent marks and the current region;
// slot payload storage is not cleared and is written on allocation.
module region_profile_slot_table import rpst_pkg::*; #(
  parameter int SLOT_COUNT = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rpst_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output rpst_out_t out_data
);

  rpst_cmd_t cmd;
  rpst_out_t res;

  // The controller owns the handshake; the datapath owns all slot state.
  rpst_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd)
  );

  rpst_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .req(in_data), .res(res)
  );

  // The result is held in a register so it stays stable while stalled.
  rpst_out_t res_r;
  always_ff @(posedge clk) begin
    if (cmd.apply || !out_valid) res_r <= res;
  end
  assign out_data = res_r;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region profile slot table testbench
// Drives start, end, clear and read requests with random gaps and output
// stalls, predicts every result with a behavioral copy of the slot table and
// compares each result field by field in a small scoreboard.
// ----------------------------------------------------------------------------

package tb_region_pkg;
  import rpst_pkg::*;

  localparam int SLOTS = 32;

  class region_scoreboard;
    // Behavioral copy of the table state.
    bit          used [SLOTS];
    bit          running [SLOTS];
    bit          recur [SLOTS];
    bit          par_ok [SLOTS];
    bit [4:0]    par_idx [SLOTS];
    bit [31:0]   kfile [SLOTS];
    bit [19:0]   kline [SLOTS];
    bit [31:0]   ticks [SLOTS];
    bit [31:0]   t_start [SLOTS];
    bit [31:0]   iters [SLOTS];
    bit          cur_ok;
    bit [4:0]    cur_idx;
    rpst_out_t   pending [$];
    int          errors;

    function new();
      errors = 0;
      cur_ok = 0;
      cur_idx = 0;
      foreach (used[i]) begin
        used[i] = 0;
        running[i] = 0;
        par_ok[i] = 0;
        par_idx[i] = 0;
      end
    endfunction

    function rpst_out_t build(logic [2:0] st, int idx, bit has_slot);
      rpst_out_t r;
      r = '0;
      r.status = st;
      r.slot_index = idx[4:0];
      if (has_slot && idx < SLOTS && used[idx]) begin
        r.slot_used = 1;
        r.slot_ticks = ticks[idx];
        r.slot_iterations = iters[idx];
        r.slot_recursive = recur[idx];
        r.parent_valid = par_ok[idx];
        r.parent_index = par_ok[idx] ? par_idx[idx] : 5'd0;
      end
      r.current_valid = cur_ok;
      r.current_index = cur_ok ? cur_idx : 5'd0;
      return r;
    endfunction

    function int lookup(logic [31:0] f, logic [19:0] l);
      for (int i = 0; i < SLOTS; i++)
        if (used[i] && kfile[i] == f && kline[i] == l) return i;
      return -1;
    endfunction

    // Notes an accepted request and queues the result it must produce.
    function void note_request(rpst_in_t q);
      int hit;
      int fr;
      hit = -1;
      fr = -1;
      case (q.kind)
        KIND_START: begin
          hit = lookup(q.site_file, q.site_line);
          if (hit >= 0) begin
            if (running[hit]) begin
              recur[hit] = 1;
              cur_ok = 1;
              cur_idx = hit[4:0];
              pending.push_back(build(ST_RECURSION, hit, 1));
            end else begin
              iters[hit] = iters[hit] + 1;
              t_start[hit] = q.now_ticks;
              running[hit] = 1;
              cur_ok = 1;
              cur_idx = hit[4:0];
              pending.push_back(build(ST_RESUMED, hit, 1));
            end
          end else begin
            for (int i = SLOTS - 1; i >= 0; i--) if (!used[i]) fr = i;
            if (fr < 0) begin
              pending.push_back(build(ST_FULL, 0, 0));
            end else begin
              used[fr] = 1;
              kfile[fr] = q.site_file;
              kline[fr] = q.site_line;
              par_ok[fr] = cur_ok;
              par_idx[fr] = cur_ok ? cur_idx : 5'd0;
              ticks[fr] = 0;
              iters[fr] = 1;
              recur[fr] = 0;
              t_start[fr] = q.now_ticks;
              running[fr] = 1;
              cur_ok = 1;
              cur_idx = fr[4:0];
              pending.push_back(build(ST_ALLOCATED, fr, 1));
            end
          end
        end
        KIND_END: begin
          hit = lookup(q.site_file, q.site_line);
          if (hit < 0) begin
            pending.push_back(build(ST_UNMATCHED, 0, 0));
          end else begin
            if (running[hit]) begin
              ticks[hit] = ticks[hit] + (q.now_ticks - t_start[hit]);
              running[hit] = 0;
            end
            cur_ok = par_ok[hit];
            cur_idx = par_ok[hit] ? par_idx[hit] : 5'd0;
            pending.push_back(build(ST_STOPPED, hit, 1));
          end
        end
        KIND_CLEAR: begin
          foreach (used[i]) begin
            used[i] = 0;
            running[i] = 0;
            par_ok[i] = 0;
            par_idx[i] = 0;
          end
          cur_ok = 0;
          cur_idx = 0;
          pending.push_back(build(ST_CLEARED, 0, 0));
        end
        default: begin
          pending.push_back(build(ST_READ, q.read_index, 1));
        end
      endcase
    endfunction

    // Compares one accepted result against the oldest expectation.
    function void check_result(rpst_out_t got);
      rpst_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
      if (got.slot_index !== e.slot_index)
        $display("%0t: slot_index expected %0d actual %0d", $time, e.slot_index,
                 got.slot_index);
      if (got.slot_used !== e.slot_used)
        $display("%0t: slot_used expected %0d actual %0d", $time, e.slot_used,
                 got.slot_used);
      if (got.slot_ticks !== e.slot_ticks)
        $display("%0t: slot_ticks expected %h actual %h", $time, e.slot_ticks,
                 got.slot_ticks);
      if (got.slot_iterations !== e.slot_iterations)
        $display("%0t: slot_iterations expected %h actual %h", $time,
                 e.slot_iterations, got.slot_iterations);
      if (got.slot_recursive !== e.slot_recursive)
        $display("%0t: slot_recursive expected %0d actual %0d", $time,
                 e.slot_recursive, got.slot_recursive);
      if (got.parent_valid !== e.parent_valid)
        $display("%0t: parent_valid expected %0d actual %0d", $time, e.parent_valid,
                 got.parent_valid);
      if (got.parent_index !== e.parent_index)
        $display("%0t: parent_index expected %0d actual %0d", $time, e.parent_index,
                 got.parent_index);
      if (got.current_valid !== e.current_valid)
        $display("%0t: current_valid expected %0d actual %0d", $time,
                 e.current_valid, got.current_valid);
      if (got.current_index !== e.current_index)
        $display("%0t: current_index expected %0d actual %0d", $time,
                 e.current_index, got.current_index);
      if (got !== e) errors++;
    endfunction
  endclass
endpackage

module tb_top;
  import rpst_pkg::*;
  import tb_region_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  rpst_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  rpst_out_t out_data;

  region_scoreboard sb;
  bit        hold_off;     // long receiver stall requested by the stimulus

  // A small pool of site keys so that starts and ends keep finding each other.
  logic [31:0] key_files [8];
  logic [19:0] key_lines [8];
  logic [31:0] clock_ticks;

  region_profile_slot_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  // The scoreboard sees a request at the very edge that accepts it, so its
  // state always matches what the block has taken in.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver: stalls on its own random pattern, with quiet stretches, and
  // holds off for a long run of cycles whenever the stimulus asks for it.
  initial begin
    int mode;
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (200) @(negedge clk);
        hold_off = 0;
        out_stall <= 0;
      end else begin
        mode = (clock_ticks / 300) % 3;
        if (mode == 0) out_stall <= 0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  always @(posedge clk) clock_ticks <= rst_n ? clock_ticks + $urandom_range(1, 40) : 0;

  // Offers one request and holds it until the block takes it.
  task automatic send_request(rpst_in_t q);
    in_data <= q;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 0;
    repeat (n) @(negedge clk);
  endtask

  function automatic rpst_in_t make_request(logic [1:0] k, int key, logic [31:0] t);
    rpst_in_t q;
    q.kind = k;
    q.site_file = key_files[key];
    q.site_line = key_lines[key];
    q.now_ticks = t;
    q.read_index = 5'($urandom);
    return q;
  endfunction

  // Sends a nested region sequence: starts on a chain of keys, then ends.
  task automatic nested_regions(int depth);
    int chain [$];
    for (int i = 0; i < depth; i++) begin
      chain.push_back($urandom_range(0, 7));
      send_request(make_request(KIND_START, chain[i], clock_ticks));
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 6));
    end
    for (int i = depth - 1; i >= 0; i--)
      send_request(make_request(KIND_END, chain[i], clock_ticks));
  endtask

  initial begin
    rpst_in_t q;
    int burst;
    int sent;
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    hold_off = 0;
    for (int i = 0; i < 8; i++) begin
      key_files[i] = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
      key_lines[i] = (i == 0) ? 20'h0 : (i == 1) ? 20'hF_FFFF : 20'($urandom);
    end
    repeat (10) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed: reads of an empty table, unmatched end, extremes of keys and
    // time, recursion, end of a stopped slot, wrapping ticks, a full table.
    q = '0; q.kind = KIND_READ; q.read_index = 5'd0; send_request(q);
    q.read_index = 5'd31; send_request(q);
    send_request(make_request(KIND_END, 0, 32'h0));
    send_request(make_request(KIND_START, 0, 32'hFFFF_FFF0));
    send_request(make_request(KIND_START, 1, 32'h0));
    send_request(make_request(KIND_START, 1, 32'h5));
    send_request(make_request(KIND_END, 1, 32'h20));
    send_request(make_request(KIND_END, 1, 32'h30));
    send_request(make_request(KIND_END, 0, 32'h0000_0010));
    send_request(make_request(KIND_START, 0, 32'h100));
    send_request(make_request(KIND_END, 0, 32'hFFFF_FFFF));
    q = '0; q.kind = KIND_READ; q.read_index = 5'd0; send_request(q);
    q.read_index = 5'd1; send_request(q);
    for (int i = 0; i < 32; i++) begin
      q = '0; q.kind = KIND_START; q.site_file = 32'hA000_0000 + i;
      q.site_line = 20'(i); q.now_ticks = i; send_request(q);
    end
    q.site_file = 32'hDEAD_BEEF; send_request(q);
    q = '0; q.kind = KIND_READ; q.read_index = 5'd31; send_request(q);
    q = '0; q.kind = KIND_CLEAR; q.site_file = '1; q.site_line = '1;
    q.now_ticks = '1; q.read_index = '1; send_request(q);

    // Random: mostly nested start/end sequences over a small key pool, with
    // reads, clears and unmatched noise mixed in.
    sent = 0;
    while (sent < 2000) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            burst = $urandom_range(1, 5);
            nested_regions(burst);
            sent += 2 * burst;
          end
          4, 5: begin
            q = make_request(2'($urandom_range(0, 1)), $urandom_range(0, 7), clock_ticks);
            send_request(q);
            sent++;
          end
          6, 7: begin
            q = make_request(KIND_READ, 0, clock_ticks);
            q.site_file = $urandom; q.site_line = 20'($urandom);
            send_request(q);
            sent++;
          end
          8: begin
            q = '0;
            q.kind = 2'($urandom); q.site_file = $urandom; q.site_line = 20'($urandom);
            q.now_ticks = $urandom; q.read_index = 5'($urandom);
            if (q.kind == KIND_CLEAR && $urandom_range(0, 3) != 0) q.kind = KIND_READ;
            send_request(q);
            sent++;
          end
          default: begin
            if ($urandom_range(0, 5) == 0) begin
              q = make_request(KIND_CLEAR, 0, clock_ticks);
              send_request(q);
              sent++;
            end
          end
        endcase
        if (sent > 1000 && sent < 1020) hold_off = 1;
      end
      idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10));
    end
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("Regression FAIL");
    $finish;
  end
endmodule
